// ===== sv/itsw_pkg.sv =====
package itsw_pkg;

  // Input item: load a symbol-table slot or generate one word.
  typedef struct packed {
    logic        mode;
    logic [6:0]  symbol_slot;
    logic [7:0]  symbol_code;
    logic [47:0] word_index;
  } in_item_t;

  // One character of a generated word.
  typedef struct packed {
    logic [7:0] symbol_char;
    logic [3:0] char_position;
    logic       word_end;
  } out_item_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_GEN  = 1'b1;

  // Register index, taken from paddr[2].
  localparam int  REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_COUNT = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_WORD_LENGTH  = 1'b1;

  localparam int  INDEX_W = 48;
  localparam int  HALF_W  = 24;
  localparam int  RADIX_W = 8;
  localparam int  CHAR_W  = 8;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_MUL_HI,
    ENG_FIX_HI,
    ENG_MUL_LO,
    ENG_FIX_LO,
    ENG_DRAIN,
    ENG_HAND
  } eng_state_t;

endpackage

// ===== sv/index_to_symbol_word_top.sv =====
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall    in_data  (itsw_pkg::in_item_t)
// out      output     out_valid / out_stall  out_data (itsw_pkg::out_item_t)
// cfg      input      APB write/read         symbol_count @0x0, word_length @0x4
//
// A load request writes its slot when the engine takes it. For a generate request,
// each digit runs two 24-bit halves through one reciprocal-multiply divide step
// (multiply, then fix); the symbol table read overlaps the next digit. Characters
// leave a word buffer one per cycle unless stalled, overlapping the next word.
// rst is synchronous; it clears control state, the symbol table keeps its contents.
// out_stall holds the output register; the pending request register takes one request
// while the engine works, then in_stall stays high until the engine picks it up.
module index_to_symbol_word_top #(
  parameter int TABLE_DEPTH     = 128,
  parameter int MAX_WORD_LENGTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  itsw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itsw_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import itsw_pkg::*;

  localparam int LEN_W = $clog2(MAX_WORD_LENGTH + 1);
  localparam int PW    = (MAX_WORD_LENGTH > 1) ? $clog2(MAX_WORD_LENGTH) : 1;

  logic [7:0]                       symbol_count;
  logic [4:0]                       word_length;
  logic [REG_IDX_W-1:0]             reg_idx;
  logic                             wr_en;
  logic                             xfer_valid;
  logic [LEN_W-1:0]                 xfer_len;
  logic [MAX_WORD_LENGTH-1:0][7:0]  xfer_chars;
  logic                             xfer_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_count <= 8'd2;
      word_length  <= 5'd1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SYMBOL_COUNT: symbol_count <= pwdata[7:0];
        REG_WORD_LENGTH:  word_length  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SYMBOL_COUNT: prdata = {24'd0, symbol_count};
      REG_WORD_LENGTH:  prdata = {27'd0, word_length};
      default:          prdata = '0;
    endcase
  end

  itsw_engine #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
    .LEN_W           (LEN_W),
    .PW              (PW)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .symbol_count (symbol_count),
    .word_length  (word_length),
    .xfer_valid   (xfer_valid),
    .xfer_len     (xfer_len),
    .xfer_chars   (xfer_chars),
    .xfer_free    (xfer_free)
  );

  itsw_emitter #(
    .MAX_WORD_LENGTH (MAX_WORD_LENGTH),
    .LEN_W           (LEN_W),
    .PW              (PW)
  ) u_emitter (
    .clk        (clk),
    .rst        (rst),
    .xfer_valid (xfer_valid),
    .xfer_len   (xfer_len),
    .xfer_chars (xfer_chars),
    .xfer_free  (xfer_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== sv/itsw_div_step.sv =====
module itsw_div_step (
  input  logic        clk,
  input  logic        load,
  input  logic [31:0] x_in,
  input  logic [31:0] recip,
  input  logic [7:0]  radix,
  output logic [23:0] q,
  output logic [7:0]  rem
);
  import itsw_pkg::*;

  logic [63:0]       prod;
  logic [31:0]       x_reg;
  logic [HALF_W-1:0] qe_reg;
  logic [31:0]       back;
  logic [31:0]       diff;
  logic [8:0]        diff9;

  // Estimate from the reciprocal; it is low by at most one.
  assign prod = 64'(x_in) * 64'(recip);

  always_ff @(posedge clk) begin
    if (load) begin
      x_reg  <= x_in;
      qe_reg <= prod[32+HALF_W-1:32];
    end
  end

  assign back  = 32'(qe_reg) * 32'(radix);
  assign diff  = x_reg - back;
  assign diff9 = diff[8:0];

  always_comb begin
    if (diff9 >= {1'b0, radix}) begin
      q   = qe_reg + 24'd1;
      rem = 8'(diff9 - {1'b0, radix});
    end else begin
      q   = qe_reg;
      rem = diff9[7:0];
    end
  end

endmodule

// ===== sv/itsw_engine.sv =====
module itsw_engine #(
  parameter int TABLE_DEPTH     = 128,
  parameter int MAX_WORD_LENGTH = 16,
  parameter int LEN_W           = 5,
  parameter int PW              = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  itsw_pkg::in_item_t                    in_data,
  input  logic [7:0]                            symbol_count,
  input  logic [4:0]                            word_length,
  output logic                                  xfer_valid,
  output logic [LEN_W-1:0]                      xfer_len,
  output logic [MAX_WORD_LENGTH-1:0][7:0]       xfer_chars,
  input  logic                                  xfer_free
);
  import itsw_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  eng_state_t state, state_next;

  logic                    pend_valid;
  in_item_t                pend;
  logic                    accept;
  logic                    take;
  logic                    we;

  logic [RADIX_W-1:0]      radix_c;
  logic [LEN_W-1:0]        len_c;
  logic [31:0]             recip_tab [256];

  logic [INDEX_W-1:0]      n;
  logic [RADIX_W-1:0]      r_used;
  logic [31:0]             recip;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        j;
  logic [HALF_W-1:0]       q_hi;
  logic [RADIX_W-1:0]      rem;

  logic                    div_load;
  logic [31:0]             div_x;
  logic [HALF_W-1:0]       div_q;
  logic [RADIX_W-1:0]      div_rem;

  logic [CHAR_W-1:0]       mem [TABLE_DEPTH];
  logic [CHAR_W-1:0]       ram_q;
  logic                    rd_v;
  logic [PW-1:0]           rd_pos;
  logic [MAX_WORD_LENGTH-1:0][CHAR_W-1:0] char_buf;

  // Reciprocal table floor(2^32 / r), worked out at elaboration.
  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam logic [31:0] RV = (g < 2) ? 32'd0 : 32'((64'd1 << 32) / g);
    assign recip_tab[g] = RV;
  end

  assign radix_c = (symbol_count < 8'd2) ? 8'd2 :
                   (32'(symbol_count) > TABLE_DEPTH) ? 8'(TABLE_DEPTH) : symbol_count;
  assign len_c   = (word_length == 5'd0) ? LEN_W'(1) :
                   (32'(word_length) > MAX_WORD_LENGTH) ? LEN_W'(MAX_WORD_LENGTH) :
                   LEN_W'(word_length);

  assign accept   = in_valid && !in_stall;
  assign in_stall = pend_valid && !take;
  assign we       = take && (pend.mode == MODE_LOAD) &&
                    (32'(pend.symbol_slot) < TABLE_DEPTH);

  always_comb begin
    state_next = state;
    take       = 1'b0;
    xfer_valid = 1'b0;
    case (state)
      ENG_IDLE: begin
        if (pend_valid) begin
          take = 1'b1;
          if (pend.mode == MODE_GEN) state_next = ENG_MUL_HI;
        end
      end
      ENG_MUL_HI: state_next = ENG_FIX_HI;
      ENG_FIX_HI: state_next = ENG_MUL_LO;
      ENG_MUL_LO: state_next = ENG_FIX_LO;
      ENG_FIX_LO: begin
        if (j == len - LEN_W'(1)) state_next = ENG_DRAIN;
        else state_next = ENG_MUL_HI;
      end
      ENG_DRAIN: state_next = ENG_HAND;
      ENG_HAND: begin
        if (xfer_free) begin
          xfer_valid = 1'b1;
          state_next = ENG_IDLE;
          // hand the word over and pick up the next request together
          if (pend_valid) begin
            take = 1'b1;
            if (pend.mode == MODE_GEN) state_next = ENG_MUL_HI;
          end
        end
      end
      default: state_next = ENG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ENG_IDLE;
      pend_valid <= 1'b0;
      rd_v       <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= (state == ENG_FIX_LO);
      if (accept) pend_valid <= 1'b1;
      else if (take) pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) pend <= in_data;
    if (take) begin
      n      <= pend.word_index;
      r_used <= radix_c;
      recip  <= recip_tab[radix_c];
      len    <= len_c;
      j      <= '0;
    end
    if (state == ENG_FIX_HI) begin
      q_hi <= div_q;
      rem  <= div_rem;
    end
    if (state == ENG_FIX_LO) begin
      n      <= {q_hi, div_q};
      rd_pos <= PW'(len - LEN_W'(1) - j);
      j      <= j + LEN_W'(1);
    end
    if (rd_v) char_buf[rd_pos] <= ram_q;
  end

  // Symbol table: one write port for loads, one read port for digits.
  always_ff @(posedge clk) begin
    if (we) mem[AW'(pend.symbol_slot)] <= pend.symbol_code;
    if (state == ENG_FIX_LO) ram_q <= mem[div_rem[AW-1:0]];
  end

  // High half first with a zero remainder, then the low half.
  assign div_load = (state == ENG_MUL_HI) || (state == ENG_MUL_LO);
  assign div_x    = (state == ENG_MUL_HI) ? {8'd0, n[INDEX_W-1:HALF_W]}
                                          : {rem, n[HALF_W-1:0]};

  itsw_div_step u_div (
    .clk   (clk),
    .load  (div_load),
    .x_in  (div_x),
    .recip (recip),
    .radix (r_used),
    .q     (div_q),
    .rem   (div_rem)
  );

  assign xfer_len   = len;
  assign xfer_chars = char_buf;

  a_rem_hi: assert property (@(posedge clk) disable iff (rst)
    state == ENG_FIX_HI |-> div_rem < r_used)
    else $error("high-half remainder not below radix");

  a_rem_lo: assert property (@(posedge clk) disable iff (rst)
    state == ENG_FIX_LO |-> div_rem < r_used)
    else $error("digit not below radix");

  a_hand_after_write: assert property (@(posedge clk) disable iff (rst)
    xfer_valid |-> !rd_v)
    else $error("word handed over before its last character was written");

  a_gen_starts: assert property (@(posedge clk) disable iff (rst)
    take && pend.mode == MODE_GEN |=> state == ENG_MUL_HI && j == '0)
    else $error("generate request did not start the digit loop");

endmodule

// ===== sv/itsw_emitter.sv =====
module itsw_emitter #(
  parameter int MAX_WORD_LENGTH = 16,
  parameter int LEN_W           = 5,
  parameter int PW              = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             xfer_valid,
  input  logic [LEN_W-1:0]                 xfer_len,
  input  logic [MAX_WORD_LENGTH-1:0][7:0]  xfer_chars,
  output logic                             xfer_free,
  output logic                             out_valid,
  input  logic                             out_stall,
  output itsw_pkg::out_item_t              out_data
);
  import itsw_pkg::*;

  logic                                   ob_valid;
  logic [MAX_WORD_LENGTH-1:0][CHAR_W-1:0] chars;
  logic [LEN_W-1:0]                       ob_len;
  logic [PW-1:0]                          ob_pos;
  logic                                   ob_last;
  logic                                   load_out;

  assign xfer_free = !ob_valid;
  assign ob_last   = (ob_pos == PW'(ob_len - LEN_W'(1)));
  assign load_out  = ob_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (xfer_valid) ob_valid <= 1'b1;
      else if (load_out && ob_last) ob_valid <= 1'b0;
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer_valid) begin
      chars  <= xfer_chars;
      ob_len <= xfer_len;
      ob_pos <= '0;
    end else if (load_out) begin
      ob_pos <= ob_pos + PW'(1);
    end
    if (load_out) begin
      out_data.symbol_char   <= chars[ob_pos];
      out_data.char_position <= 4'(ob_pos);
      out_data.word_end      <= ob_last;
    end
  end

endmodule
